@@ hdl/frt_pkg.sv @@
// ----------------------------------------------------------------------------
// frt_pkg: shared types and constants for the fragment reassembly tracker
// Context table sizing, status codes and the header/result structs passed
// between the top level and the context table.
// ----------------------------------------------------------------------------
package frt_pkg;

  localparam int unsigned CONTEXTS    = 8;
  localparam int unsigned CTX_IDX_W   = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
  localparam int unsigned OBJ_W       = 64;
  localparam int unsigned FRAG_W      = 64;
  localparam int unsigned LEN_W       = 32;
  localparam int unsigned OPEN_W      = 4;
  localparam int unsigned STATUS_W    = 2;

  localparam logic [LEN_W-1:0] MAX_MSG_RESET = LEN_W'(64 * 1024 * 1024);

  // Config register indexes
  localparam logic REG_MAX_MSG = 1'b0;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_NO_FREE   = 2'd3
  } status_e;

  typedef struct packed {
    logic [OBJ_W-1:0]  obj_key;
    logic [FRAG_W-1:0] frag_seq;
    logic              start_flag;
    logic              end_flag;
    logic [LEN_W-1:0]  payload_length;
  } frt_hdr_t;

  typedef struct packed {
    status_e            status;
    logic               message_done;
    logic [OBJ_W-1:0]   done_obj_key;
    logic [LEN_W-1:0]   message_length;
    logic [OPEN_W-1:0]  open_contexts;
  } frt_res_t;

  // Number of set bits, modulo 2^OPEN_W
  function automatic logic [OPEN_W-1:0] count_ones(input logic [CONTEXTS-1:0] v);
    logic [OPEN_W-1:0] n;
    n = '0;
    for (int i = 0; i < CONTEXTS; i++) begin
      n = n + OPEN_W'(v[i]);
    end
    return n;
  endfunction

endpackage

@@ hdl/frt_ctx_table.sv @@
// ----------------------------------------------------------------------------
// frt_ctx_table: reassembly context table
// Holds the open contexts, matches one header against all of them in
// parallel, computes the result and updates the table when told to.
// ----------------------------------------------------------------------------
module frt_ctx_table
  import frt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             upd_i,
  input  frt_hdr_t         hdr_i,
  input  logic [LEN_W-1:0] limit_i,
  output frt_res_t         res_o
);

  logic [CONTEXTS-1:0] valid_q, valid_d;
  logic [OBJ_W-1:0]    obj_q  [CONTEXTS];
  logic [FRAG_W-1:0]   next_q [CONTEXTS];
  logic [LEN_W-1:0]    cnt_q  [CONTEXTS];

  logic [CONTEXTS-1:0]  hit_vec;
  logic                 hit_any, free_any;
  logic [CTX_IDX_W-1:0] hit_idx, free_idx, sel_idx;
  logic [FRAG_W-1:0]    cur_next;
  logic [LEN_W-1:0]     cur_cnt;
  logic [LEN_W:0]       total;
  logic                 wr_ok;
  status_e              status;

  always_comb begin
    hit_any  = 1'b0;
    free_any = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = CONTEXTS - 1; i >= 0; i--) begin
      hit_vec[i] = valid_q[i] && (obj_q[i] == hdr_i.obj_key);
      if (hit_vec[i]) begin
        hit_any = 1'b1;
        hit_idx = CTX_IDX_W'(i);
      end
      if (!valid_q[i]) begin
        free_any = 1'b1;
        free_idx = CTX_IDX_W'(i);
      end
    end
  end

  // A start fragment works on a fresh context: next id 0, no bytes yet
  always_comb begin
    if (hdr_i.start_flag) begin
      sel_idx  = free_idx;
      cur_next = '0;
      cur_cnt  = '0;
    end else begin
      sel_idx  = hit_idx;
      cur_next = next_q[hit_idx];
      cur_cnt  = cnt_q[hit_idx];
    end
    total = {1'b0, cur_cnt} + {1'b0, hdr_i.payload_length};
  end

  always_comb begin
    valid_d = valid_q;
    wr_ok   = 1'b0;
    if (hdr_i.start_flag && ((hdr_i.frag_seq != '0) || hit_any)) begin
      status = ST_MALFORMED;
    end else if (hdr_i.start_flag && !free_any) begin
      status = ST_NO_FREE;
    end else if (!hdr_i.start_flag && !hit_any) begin
      status = ST_MALFORMED;
    end else if (hdr_i.frag_seq != cur_next) begin
      status = ST_MALFORMED;
    end else if ((hdr_i.payload_length != '0) && (total > {1'b0, limit_i})) begin
      status = ST_OVERFLOW;
      // a start fragment that overflows never leaves a context behind
      valid_d[sel_idx] = 1'b0;
    end else begin
      status = ST_OK;
      wr_ok  = 1'b1;
      valid_d[sel_idx] = !hdr_i.end_flag;
    end
  end

  always_comb begin
    res_o.status         = status;
    res_o.message_done   = wr_ok && hdr_i.end_flag;
    res_o.done_obj_key   = res_o.message_done ? hdr_i.obj_key : '0;
    res_o.message_length = res_o.message_done ? total[LEN_W-1:0] : '0;
    res_o.open_contexts  = count_ones(valid_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (upd_i) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_i && wr_ok) begin
      obj_q[sel_idx]  <= hdr_i.obj_key;
      next_q[sel_idx] <= cur_next + FRAG_W'(1);
      cnt_q[sel_idx]  <= total[LEN_W-1:0];
    end
  end

endmodule

@@ hdl/fragment_reassembly_tracker.sv @@
// ----------------------------------------------------------------------------
// fragment_reassembly_tracker: message fragment reassembly by object id
// Tracks open reassembly contexts from decoded fragment headers and reports
// one status result per header.
// ----------------------------------------------------------------------------
//  channel   | direction | contents
//  ----------+-----------+--------------------------------------------------
//  s_axis    | in        | fragment header, one per transfer
//  m_axis    | out       | status result, one per header
//  apb       | in/out    | max_message_bytes at byte address 0
//
//  A header is held in the input register, passes the parallel context match
//  and table update, and its result is held in the result register; one header
//  is taken every cycle while the result register is not stalled.
//  Reset clears the context table valid bits and sets max_message_bytes to
//  64 MiB. A stalled result register holds the input register, which in turn
//  drops s_axis_tready.
// ----------------------------------------------------------------------------
module fragment_reassembly_tracker
  import frt_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  // fragment header input
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [159:0] s_axis_tdata,  // obj_key[63:0], frag_seq[127:64],
                                      // payload_length[159:128]
  input  logic         s_axis_tuser,  // start_flag
  input  logic         s_axis_tlast,  // end_flag
  // result output
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,  // done_obj_key[63:0], message_length[95:64],
                                      // open_contexts[99:96], zero[103:100]
  output logic [2:0]   m_axis_tuser,  // status[1:0], message_done[2]
  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  frt_hdr_t         hdr_q;
  logic             in_valid_q, in_valid_d;
  frt_res_t         res, res_q;
  logic             out_valid_q, out_valid_d;
  logic [LEN_W-1:0] max_q;
  logic             advance, take_in, process, cfg_wr;

  // ---- configuration ----
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MAX_MSG);
  assign prdata = (paddr[2] == REG_MAX_MSG) ? max_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MAX_MSG_RESET;
    end else if (cfg_wr && (pwdata != '0)) begin
      max_q <= pwdata;
    end
  end

  // ---- handshake ----
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign take_in       = s_axis_tvalid && s_axis_tready;
  assign process       = in_valid_q && advance;
  assign in_valid_d    = take_in || (in_valid_q && !advance);
  assign out_valid_d   = process || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      hdr_q.obj_key        <= s_axis_tdata[63:0];
      hdr_q.frag_seq       <= s_axis_tdata[127:64];
      hdr_q.payload_length <= s_axis_tdata[159:128];
      hdr_q.start_flag     <= s_axis_tuser;
      hdr_q.end_flag       <= s_axis_tlast;
    end
    if (process) begin
      res_q <= res;
    end
  end

  frt_ctx_table u_ctx_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (process),
    .hdr_i   (hdr_q),
    .limit_i (max_q),
    .res_o   (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, res_q.open_contexts, res_q.message_length,
                          res_q.done_obj_key};
  assign m_axis_tuser  = {res_q.message_done, res_q.status};

endmodule
